// ----- design/pff_pkg.sv -----
`timescale 1ns / 1ps

package pff_pkg;

    // Fixed header layout: 4 magic bytes, 4 sequence bytes, 1 index/count byte
    localparam int HEADER_BYTES = 9;
    localparam int COUNT_W      = 4;
    localparam int LEN_W        = 16;
    localparam int ACC_W        = LEN_W + COUNT_W;

    // Configuration register indexes
    localparam logic REG_FRAGMENT_SIZE = 1'b0;
    localparam logic REG_HEADER_MAGIC  = 1'b1;

    // Result kinds driven into the output register
    localparam logic [1:0] EMIT_ERR  = 2'd0;
    localparam logic [1:0] EMIT_HDR  = 2'd1;
    localparam logic [1:0] EMIT_BODY = 2'd2;

    typedef struct packed {
        logic [7:0]         payload_byte;
        logic               message_start;
        logic [LEN_W-1:0]   message_length;
        logic signed [31:0] msg_seq;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       fragment_end;
        logic       message_end;
        logic       status;
        logic       run_last;
    } out_beat_t;

    typedef struct packed {
        logic       load_in;
        logic       div_init;
        logic       div_step;
        logic       commit;
        logic       emit;
        logic [1:0] emit_sel;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic in_msg;
        logic init_bad;
        logic div_ge;
        logic k_max;
        logic offset_zero;
        logic hdr_last;
        logic out_free;
    } sts_t;

endpackage

// ----- design/packet_fragment_framer.sv -----
`timescale 1ns / 1ps
// Flow: a payload beat is registered on acceptance and then decided on; a message's
// first beat runs the count search (up to MAX_FRAGMENTS), and a fragment header goes
// out ahead of the first body byte of each fragment. A new beat is accepted only once
// the controller is back in idle; all results leave through one output register.
// Reset: synchronous, active low; clears the controller, the output valid, the message
// flag and header byte counter, and restores fragment_size 1400 and header_magic 0xFFFFFFFE.
module packet_fragment_framer #(
    parameter int MAX_FRAGMENTS = 15
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  pff_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pff_pkg::out_beat_t m_data
);

    pff_pkg::cmd_t cmd;
    pff_pkg::sts_t sts;

    // Sequencer
    pff_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Registers, count search and byte selection
    pff_datapath #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- design/pff_ctrl.sv -----
`timescale 1ns / 1ps

module pff_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pff_pkg::sts_t sts,
    output pff_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_ERR    = 3'd3;
    localparam logic [2:0] ST_HDR    = 3'd4;
    localparam logic [2:0] ST_BODY   = 3'd5;

    logic [2:0] state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.emit_sel = pff_pkg::EMIT_BODY;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.start) begin
                    cmd.div_init = 1'b1;
                    state_next   = sts.init_bad ? ST_ERR : ST_DIV;
                end else if (!sts.in_msg) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = sts.offset_zero ? ST_HDR : ST_BODY;
                end
            end
            ST_DIV: begin
                // one multiple of the body size per cycle until it covers the length or the count is at its maximum
                if (sts.div_ge) begin
                    cmd.commit = 1'b1;
                    state_next = ST_HDR;
                end else if (sts.k_max) begin
                    state_next = ST_ERR;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_ERR: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = pff_pkg::EMIT_ERR;
                    state_next   = ST_IDLE;
                end
            end
            ST_HDR: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = pff_pkg::EMIT_HDR;
                    if (sts.hdr_last) begin
                        state_next = ST_BODY;
                    end
                end
            end
            ST_BODY: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = pff_pkg::EMIT_BODY;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/pff_datapath.sv -----
`timescale 1ns / 1ps

module pff_datapath #(
    parameter int MAX_FRAGMENTS = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_wdata,
    input  pff_pkg::in_beat_t    s_data,
    output pff_pkg::out_beat_t   m_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  pff_pkg::cmd_t        cmd,
    output pff_pkg::sts_t        sts
);

    localparam int LW = pff_pkg::LEN_W;
    localparam int CW = pff_pkg::COUNT_W;
    localparam int AW = pff_pkg::ACC_W;

    // Configuration
    logic [LW-1:0] frag_size_reg;
    logic [31:0]   magic_reg;

    // Held input beat
    pff_pkg::in_beat_t in_reg;

    // Message state
    logic          in_message_reg, in_message_next;
    logic [LW-1:0] body_bytes_reg;
    logic [CW-1:0] frag_total_reg;
    logic [CW-1:0] frag_index_reg, frag_index_next;
    logic [LW-1:0] offset_reg, offset_next;
    logic [LW-1:0] bytes_left_reg, bytes_left_next;
    logic [31:0]   held_seq_reg;

    // Fragment count search and header byte counter
    logic [AW-1:0] acc_reg;
    logic [CW-1:0] k_reg;
    logic [3:0]    hcnt_reg;

    // Output register
    logic               m_valid_reg, m_valid_next;
    pff_pkg::out_beat_t m_data_reg, m_data_next;

    logic [LW-1:0] body_calc;
    logic [LW-1:0] off_inc;
    logic [LW-1:0] left_dec;
    logic          msg_end;
    logic          frag_end;
    logic [7:0]    hdr_byte;
    logic          out_free;

    assign body_calc = frag_size_reg - LW'(pff_pkg::HEADER_BYTES);
    assign off_inc   = offset_reg + 1'b1;
    assign left_dec  = bytes_left_reg - 1'b1;
    assign msg_end   = (left_dec == '0);
    assign frag_end  = msg_end || (off_inc >= body_bytes_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // Header byte select: magic, then sequence, then index/count nibbles
    always_comb begin
        case (hcnt_reg)
            4'd0, 4'd1, 4'd2, 4'd3: hdr_byte = 8'(magic_reg >> {hcnt_reg[1:0], 3'b000});
            4'd4, 4'd5, 4'd6, 4'd7: hdr_byte = 8'(held_seq_reg >> {hcnt_reg[1:0], 3'b000});
            default:                hdr_byte = {frag_index_reg, frag_total_reg};
        endcase
    end

    // Status to the controller
    always_comb begin
        sts.start       = in_reg.message_start;
        sts.in_msg      = in_message_reg;
        sts.init_bad    = (frag_size_reg <= LW'(pff_pkg::HEADER_BYTES))
                          || (in_reg.message_length == '0);
        sts.div_ge      = (acc_reg >= AW'(in_reg.message_length));
        sts.k_max       = (k_reg == CW'(MAX_FRAGMENTS));
        sts.offset_zero = (offset_reg == '0);
        sts.hdr_last    = (hcnt_reg == 4'(pff_pkg::HEADER_BYTES - 1));
        sts.out_free    = out_free;
    end

    // Message state and output next values
    always_comb begin
        in_message_next = in_message_reg;
        frag_index_next = frag_index_reg;
        offset_next     = offset_reg;
        bytes_left_next = bytes_left_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        if (cmd.commit) begin
            in_message_next = 1'b1;
            frag_index_next = '0;
            offset_next     = '0;
            bytes_left_next = in_reg.message_length;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            case (cmd.emit_sel)
                pff_pkg::EMIT_ERR: begin
                    in_message_next          = 1'b0;
                    m_data_next.message_end  = 1'b1;
                    m_data_next.status       = 1'b1;
                    m_data_next.run_last     = 1'b1;
                end
                pff_pkg::EMIT_HDR: begin
                    m_data_next.out_byte  = hdr_byte;
                    m_data_next.is_header = 1'b1;
                end
                default: begin
                    m_data_next.out_byte     = in_reg.payload_byte;
                    m_data_next.fragment_end = frag_end;
                    m_data_next.message_end  = msg_end;
                    m_data_next.run_last     = 1'b1;
                    bytes_left_next          = left_dec;
                    offset_next              = frag_end ? '0 : off_inc;
                    if (frag_end) begin
                        frag_index_next = frag_index_reg + 1'b1;
                    end
                    if (msg_end) begin
                        in_message_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frag_size_reg  <= LW'(1400);
            magic_reg      <= 32'hFFFF_FFFE;
            in_message_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            hcnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    pff_pkg::REG_FRAGMENT_SIZE: frag_size_reg <= cfg_wdata[LW-1:0];
                    pff_pkg::REG_HEADER_MAGIC:  magic_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            in_message_reg <= in_message_next;
            m_valid_reg    <= m_valid_next;
            if (cmd.emit && cmd.emit_sel == pff_pkg::EMIT_HDR) begin
                hcnt_reg <= sts.hdr_last ? '0 : hcnt_reg + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.div_init) begin
            body_bytes_reg <= body_calc;
            acc_reg        <= AW'(body_calc);
            k_reg          <= CW'(1);
        end else if (cmd.div_step) begin
            acc_reg <= acc_reg + AW'(body_bytes_reg);
            k_reg   <= k_reg + 1'b1;
        end
        if (cmd.commit) begin
            frag_total_reg <= k_reg;
            held_seq_reg   <= in_reg.msg_seq;
        end
        frag_index_reg <= frag_index_next;
        offset_reg     <= offset_next;
        bytes_left_reg <= bytes_left_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
